@@ design/prow_pkg.sv @@
package prow_pkg;

	localparam int WORD_W  = 64;
	localparam int WB_W    = 4;
	localparam int BYTES_W = 10;
	localparam int KIND_W  = 16;
	localparam int CNT_W   = 7;
	localparam int STAT_W  = 3;

	localparam logic [CNT_W-1:0] CFG_RESET  = 7'd64;
	localparam logic [WB_W-1:0]  WORD_BYTES = 4'd8;

	localparam logic OP_ENQ = 1'b0;
	localparam logic OP_DEQ = 1'b1;

	typedef enum logic [STAT_W-1:0] {
		ST_STORED = 3'd0,
		ST_LOST   = 3'd1,
		ST_REJECT = 3'd2,
		ST_WORD   = 3'd3,
		ST_EMPTY  = 3'd4
	} status_t;

	// one slot descriptor; zero bytes marks an empty slot
	typedef struct packed {
		logic [BYTES_W-1:0]       bytes;
		logic signed [KIND_W-1:0] kind;
		logic                     trunc;
	} meta_t;

	typedef struct packed {
		logic                     opcode;
		logic [WORD_W-1:0]        payload_word;
		logic [WB_W-1:0]          word_bytes;
		logic                     last_word;
		logic signed [KIND_W-1:0] kind;
	} in_t;

	typedef struct packed {
		status_t                  status;
		logic [WORD_W-1:0]        out_word;
		logic [WB_W-1:0]          out_word_bytes;
		logic [BYTES_W-1:0]       packet_bytes;
		logic signed [KIND_W-1:0] kind;
		logic                     end_of_run;
		logic                     truncated;
		logic [CNT_W-1:0]         queued_count;
		logic [CNT_W-1:0]         free_count;
	} res_t;

endpackage

@@ design/prow_ram.sv @@
module prow_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ design/prow_ctrl.sv @@
module prow_ctrl #(
	parameter int SLOTS      = 64,
	parameter int SLOT_WORDS = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [prow_pkg::CNT_W-1:0]   ring_size,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  prow_pkg::in_t                in_item,
	input  logic                         out_free,
	output logic                         res_valid,
	output prow_pkg::res_t               res
);

	localparam int IDX_W     = $clog2(SLOTS);
	localparam int WIDX_W    = (SLOT_WORDS > 1) ? $clog2(SLOT_WORDS) : 1;
	localparam int FW_W      = $clog2(SLOT_WORDS + 1);
	localparam int HC_W      = $clog2(SLOTS + 1);
	localparam int PAY_DEPTH = SLOTS * (2 ** WIDX_W);
	localparam int PAY_AW    = IDX_W + WIDX_W;
	localparam int META_W    = $bits(prow_pkg::meta_t);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_COMMIT,
		S_NEXT,
		S_DEQ,
		S_STREAM,
		S_RESULT
	} state_t;

	state_t                              state_q;
	logic [IDX_W-1:0]                    clr_q;
	logic [IDX_W-1:0]                    head_q;
	logic [IDX_W-1:0]                    tail_q;
	logic [IDX_W-1:0]                    nxt_q;
	logic [IDX_W-1:0]                    slot_q;
	logic [HC_W-1:0]                     held_q;
	logic [FW_W-1:0]                     fill_words_q;
	logic [prow_pkg::BYTES_W-1:0]        fill_bytes_q;
	logic                                fill_ovf_q;
	logic [prow_pkg::BYTES_W-1:0]        bytes_q;
	logic signed [prow_pkg::KIND_W-1:0]  kind_q;
	logic                                trunc_q;
	prow_pkg::status_t                   status_q;
	logic [prow_pkg::BYTES_W-1:0]        rem_q;
	logic [WIDX_W-1:0]                   word_q;
	logic                                pend_s1;
	logic [prow_pkg::WB_W-1:0]           wb_s1;
	logic                                last_s1;

	logic                                m_we;
	logic [IDX_W-1:0]                    m_waddr;
	prow_pkg::meta_t                     m_wdata;
	logic                                m_re;
	logic [IDX_W-1:0]                    m_raddr;
	prow_pkg::meta_t                     m_rdata;
	logic [META_W-1:0]                   m_rbits;

	logic                                p_we;
	logic [PAY_AW-1:0]                   p_waddr;
	logic                                p_re;
	logic [PAY_AW-1:0]                   p_raddr;
	logic [prow_pkg::WORD_W-1:0]         p_rdata;

	logic                                accept;
	logic                                room;
	logic [prow_pkg::WB_W-1:0]           wb_in;
	logic [prow_pkg::BYTES_W-1:0]        commit_bytes;
	logic [IDX_W-1:0]                    tail_next;
	logic [IDX_W-1:0]                    head_next;
	logic                                more;
	logic                                load;
	logic                                issue;
	logic [prow_pkg::WB_W-1:0]           wb_next;
	logic                                last_next;
	int                                  held_int;
	int                                  ring_int;

	function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i,
			input logic [prow_pkg::CNT_W-1:0] n);
		if (int'(i) + 1 >= int'(n)) begin
			return '0;
		end
		return i + 1'b1;
	endfunction

	prow_ram #(
		.WIDTH(META_W),
		.DEPTH(SLOTS)
	) u_meta_ram (
		.clk  (clk),
		.we   (m_we),
		.waddr(m_waddr),
		.wdata(m_wdata),
		.re   (m_re),
		.raddr(m_raddr),
		.rdata(m_rbits)
	);

	assign m_rdata = prow_pkg::meta_t'(m_rbits);

	prow_ram #(
		.WIDTH(prow_pkg::WORD_W),
		.DEPTH(PAY_DEPTH)
	) u_pay_ram (
		.clk  (clk),
		.we   (p_we),
		.waddr(p_waddr),
		.wdata(in_item.payload_word),
		.re   (p_re),
		.raddr(p_raddr),
		.rdata(p_rdata)
	);

	assign in_ready     = (state_q == S_IDLE);
	assign accept       = in_valid & in_ready;
	assign wb_in        = (in_item.word_bytes > prow_pkg::WORD_BYTES) ?
			prow_pkg::WORD_BYTES : in_item.word_bytes;
	assign room         = fill_words_q < FW_W'(SLOT_WORDS);
	assign commit_bytes = fill_bytes_q + (room ? prow_pkg::BYTES_W'(wb_in) : '0);
	assign tail_next    = next_idx(tail_q, ring_size);
	assign head_next    = next_idx(head_q, ring_size);

	// word streaming: one read in flight, its data waits on the RAM output
	assign more      = rem_q != '0;
	assign load      = pend_s1 & out_free;
	assign issue     = (state_q == S_STREAM) & more & (~pend_s1 | load);
	assign wb_next   = (rem_q > prow_pkg::BYTES_W'(prow_pkg::WORD_BYTES)) ?
			prow_pkg::WORD_BYTES : rem_q[prow_pkg::WB_W-1:0];
	assign last_next = rem_q <= prow_pkg::BYTES_W'(prow_pkg::WORD_BYTES);

	always_comb begin
		m_we    = 1'b0;
		m_waddr = tail_q;
		m_wdata = '0;
		m_re    = 1'b0;
		m_raddr = tail_q;
		p_we    = 1'b0;
		p_waddr = {tail_q, fill_words_q[WIDX_W-1:0]};
		p_re    = issue;
		p_raddr = {slot_q, word_q};
		case (state_q)
			S_CLEAR: begin
				m_we    = 1'b1;
				m_waddr = clr_q;
			end
			S_IDLE: begin
				if (accept) begin
					if (in_item.opcode == prow_pkg::OP_ENQ) begin
						p_we = room;
						m_re = in_item.last_word & (commit_bytes != '0);
					end else begin
						m_re    = 1'b1;
						m_raddr = head_q;
					end
				end
			end
			S_COMMIT: begin
				m_we    = 1'b1;
				m_wdata = '{bytes: bytes_q, kind: kind_q, trunc: trunc_q};
				m_re    = 1'b1;
				m_raddr = tail_next;
			end
			S_DEQ: begin
				m_we    = m_rdata.bytes != '0;
				m_waddr = head_q;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		held_int = int'(held_q);
		ring_int = int'(ring_size);
		res_valid = (state_q == S_RESULT) | ((state_q == S_STREAM) & pend_s1);
		res.status         = (state_q == S_STREAM) ? prow_pkg::ST_WORD : status_q;
		res.out_word       = (state_q == S_STREAM) ? p_rdata : '0;
		res.out_word_bytes = (state_q == S_STREAM) ? wb_s1 : '0;
		res.packet_bytes   = bytes_q;
		res.kind           = kind_q;
		res.end_of_run     = (state_q == S_STREAM) ? last_s1 : 1'b1;
		res.truncated      = trunc_q;
		res.queued_count   = prow_pkg::CNT_W'(held_int);
		res.free_count     = (held_int < ring_int) ?
				prow_pkg::CNT_W'(ring_int - held_int) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			nxt_q        <= '0;
			slot_q       <= '0;
			held_q       <= '0;
			fill_words_q <= '0;
			fill_bytes_q <= '0;
			fill_ovf_q   <= 1'b0;
			bytes_q      <= '0;
			kind_q       <= '0;
			trunc_q      <= 1'b0;
			status_q     <= prow_pkg::ST_STORED;
			rem_q        <= '0;
			word_q       <= '0;
			pend_s1      <= 1'b0;
			wb_s1        <= '0;
			last_s1      <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IDX_W'(SLOTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (in_item.opcode == prow_pkg::OP_ENQ) begin
							if (room) begin
								fill_words_q <= fill_words_q + 1'b1;
								fill_bytes_q <= commit_bytes;
							end else begin
								fill_ovf_q <= 1'b1;
							end
							if (in_item.last_word) begin
								fill_words_q <= '0;
								fill_bytes_q <= '0;
								fill_ovf_q   <= 1'b0;
								if (commit_bytes == '0) begin
									status_q <= prow_pkg::ST_REJECT;
									bytes_q  <= '0;
									kind_q   <= '0;
									trunc_q  <= 1'b0;
									state_q  <= S_RESULT;
								end else begin
									bytes_q <= commit_bytes;
									kind_q  <= in_item.kind;
									trunc_q <= fill_ovf_q | ~room;
									state_q <= S_COMMIT;
								end
							end
						end else begin
							state_q <= S_DEQ;
						end
					end
				end
				S_COMMIT: begin
					status_q <= (m_rdata.bytes != '0) ? prow_pkg::ST_LOST :
							prow_pkg::ST_STORED;
					nxt_q    <= tail_next;
					state_q  <= S_NEXT;
				end
				S_NEXT: begin
					// the next slot is the tail slot itself on a one-slot ring
					tail_q <= nxt_q;
					if ((nxt_q == tail_q) || (m_rdata.bytes != '0)) begin
						head_q <= nxt_q;
						held_q <= HC_W'(ring_size);
					end else if (int'(held_q) < SLOTS) begin
						held_q <= held_q + 1'b1;
					end
					state_q <= S_RESULT;
				end
				S_DEQ: begin
					if (m_rdata.bytes == '0) begin
						status_q <= prow_pkg::ST_EMPTY;
						bytes_q  <= '0;
						kind_q   <= '0;
						trunc_q  <= 1'b0;
						state_q  <= S_RESULT;
					end else begin
						head_q  <= head_next;
						if (held_q != '0) begin
							held_q <= held_q - 1'b1;
						end
						bytes_q <= m_rdata.bytes;
						kind_q  <= m_rdata.kind;
						trunc_q <= m_rdata.trunc;
						rem_q   <= m_rdata.bytes;
						word_q  <= '0;
						slot_q  <= head_q;
						state_q <= S_STREAM;
					end
				end
				S_STREAM: begin
					if (issue) begin
						rem_q   <= rem_q - prow_pkg::BYTES_W'(wb_next);
						word_q  <= word_q + 1'b1;
						wb_s1   <= wb_next;
						last_s1 <= last_next;
					end
					pend_s1 <= issue | (pend_s1 & ~load);
					if (load && last_s1) begin
						state_q <= S_IDLE;
					end
				end
				S_RESULT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ design/packet_ring_overwrite_oldest.sv @@
// Channel   Handshake                   Carries
// -------   -------------------------   ------------------------------------------------
// in        in_valid / in_ready         opcode, payload_word, word_bytes, last_word, kind_in
// out       out_valid / out_ready       status, out_word .. free_count (nine result fields)
// cfg       cfg_wr_en / cfg_wr_data     slots_in_use, written without wait
//
// Non-last enqueue word: written if the slot has room; the block stays idle. Last word: read the tail slot, write it
// while reading the next slot, move the pointers, present the result.
// Dequeue: one word per cycle after the slot fetch while out_ready does not stall.
// After reset the slot table is cleared; in_ready stays low until done.
// A stalled out_ready holds the output register and stops the word stream in place.
module packet_ring_overwrite_oldest #(
	parameter int SLOTS      = 64,
	parameter int SLOT_WORDS = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [prow_pkg::CNT_W-1:0]         cfg_wr_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               opcode,
	input  logic [prow_pkg::WORD_W-1:0]        payload_word,
	input  logic [prow_pkg::WB_W-1:0]          word_bytes,
	input  logic                               last_word,
	input  logic signed [prow_pkg::KIND_W-1:0] kind_in,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [prow_pkg::STAT_W-1:0]        status,
	output logic [prow_pkg::WORD_W-1:0]        out_word,
	output logic [prow_pkg::WB_W-1:0]          out_word_bytes,
	output logic [prow_pkg::BYTES_W-1:0]       packet_bytes,
	output logic signed [prow_pkg::KIND_W-1:0] kind_out,
	output logic                               end_of_run,
	output logic                               truncated,
	output logic [prow_pkg::CNT_W-1:0]         queued_count,
	output logic [prow_pkg::CNT_W-1:0]         free_count
);

	logic [prow_pkg::CNT_W-1:0] cfg_q;       // slots_in_use as written
	logic [prow_pkg::CNT_W-1:0] ring_size;   // clamped to 1..SLOTS
	prow_pkg::in_t              in_item;
	prow_pkg::res_t             res;
	logic                       res_valid;
	prow_pkg::res_t             out_q;
	logic                       out_valid_q;
	logic                       out_free;

	// Hold the ring size register; take a write whenever enable is high.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= prow_pkg::CFG_RESET;
		end else if (cfg_wr_en) begin
			cfg_q <= cfg_wr_data;
		end
	end

	// Zero counts as one slot; anything above the slot count clamps to SLOTS.
	always_comb begin
		if (cfg_q == '0) begin
			ring_size = prow_pkg::CNT_W'(1);
		end else if (int'(cfg_q) > SLOTS) begin
			ring_size = prow_pkg::CNT_W'(SLOTS);
		end else begin
			ring_size = cfg_q;
		end
	end

	assign in_item = '{
		opcode:       opcode,
		payload_word: payload_word,
		word_bytes:   word_bytes,
		last_word:    last_word,
		kind:         kind_in
	};

	prow_ctrl #(
		.SLOTS     (SLOTS),
		.SLOT_WORDS(SLOT_WORDS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.ring_size(ring_size),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_free (out_free),
		.res_valid(res_valid),
		.res      (res)
	);

	// Output register: load a result when empty or being drained this cycle.
	assign out_free = ~out_valid_q | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else if (out_free) begin
			out_valid_q <= res_valid;
			if (res_valid) begin
				out_q <= res;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_q.status;
	assign out_word       = out_q.out_word;
	assign out_word_bytes = out_q.out_word_bytes;
	assign packet_bytes   = out_q.packet_bytes;
	assign kind_out       = out_q.kind;
	assign end_of_run     = out_q.end_of_run;
	assign truncated      = out_q.truncated;
	assign queued_count   = out_q.queued_count;
	assign free_count     = out_q.free_count;

endmodule
